// ----- sv/framed_message_receiver_crc16_defines.svh -----
// Assertion helpers for the framed message receiver.
`ifndef FRAMED_MESSAGE_RECEIVER_CRC16_DEFINES_SVH
`define FRAMED_MESSAGE_RECEIVER_CRC16_DEFINES_SVH

`ifndef SYNTHESIS
`define FMR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`define FMR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FMR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define FMR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- sv/fmr_pkg.sv -----
package fmr_pkg;

  localparam logic [7:0]  FRAME_START = 8'h1B;
  localparam logic [7:0]  FRAME_TOKEN = 8'h0E;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h8408;

  localparam int unsigned PADDR_W = 3;
  localparam logic        REG_MAX_PAYLOAD = 1'b0;

  localparam logic [1:0] STATUS_BUSY  = 2'd0;
  localparam logic [1:0] STATUS_DONE  = 2'd1;
  localparam logic [1:0] STATUS_ERROR = 2'd2;

  typedef struct packed {
    logic [1:0]  status;
    logic        body_valid;
    logic [7:0]  body_byte;
    logic [15:0] body_offset;
    logic [15:0] seq_number;
    logic [15:0] msg_length;
    logic [16:0] error_position;
  } fmr_result_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- sv/fmr_cfg_regs.sv -----
module fmr_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fmr_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [15:0]                   max_payload_o
);
  import fmr_pkg::*;

  logic [15:0] max_payload_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_MAX_PAYLOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= 16'd512;
    end else if (wr_en) begin
      max_payload_q <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_MAX_PAYLOAD) begin
      prdata = {16'd0, max_payload_q};
    end
  end

  assign max_payload_o = max_payload_q;
endmodule

// ----- sv/fmr_in_reg.sv -----
module fmr_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  input  logic [7:0] s_tdata_i,
  input  logic       take_i,
  output logic       s_tready_o,
  output logic       byte_valid_o,
  output logic [7:0] byte_o
);
  logic       valid_q;
  logic [7:0] byte_q;

  assign s_tready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_tready_o) begin
      valid_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready_o && s_tvalid_i) begin
      byte_q <= s_tdata_i;
    end
  end

  assign byte_valid_o = valid_q;
  assign byte_o       = byte_q;
endmodule

// ----- sv/fmr_parser.sv -----
module fmr_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 byte_valid_i,
  input  logic [7:0]           rx_byte_i,
  input  logic [15:0]          max_payload_i,
  input  logic                 m_tready_i,
  output logic                 take_o,
  output logic                 out_valid_o,
  output fmr_pkg::fmr_result_t result_o
);
  import fmr_pkg::*;

  logic [16:0] pos_q, pos_d;
  logic [15:0] len_q, len_d;
  logic        len_hi_q, len_hi_d;
  logic [15:0] seq_q, seq_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_lo_q, crc_lo_d;
  logic [16:0] err_pos_q, err_pos_d;
  logic        out_valid_q;
  fmr_result_t result_q, result_d;

  logic [16:0] body_end;
  logic [15:0] crc_base;
  logic        ok;
  logic        done;
  logic        in_body;

  assign take_o   = byte_valid_i && (!out_valid_q || m_tready_i);
  assign body_end = {1'b0, len_q} + 17'd8;
  assign in_body  = (pos_q > 17'd7) && (pos_q < body_end);

  always_comb begin
    pos_d     = pos_q;
    len_d     = len_q;
    len_hi_d  = len_hi_q;
    seq_d     = seq_q;
    crc_lo_d  = crc_lo_q;
    err_pos_d = err_pos_q;
    crc_base  = crc_q;
    ok        = 1'b1;
    done      = 1'b0;
    result_d  = '0;

    if (in_body) begin
      result_d.body_valid  = 1'b1;
      result_d.body_byte   = rx_byte_i;
      result_d.body_offset = 16'(pos_q - 17'd8);
    end else if (pos_q == 17'd0) begin
      ok       = (rx_byte_i == FRAME_START);
      crc_base = CRC_INIT;
    end else if (pos_q == 17'd1) begin
      seq_d = {8'h00, rx_byte_i};
    end else if (pos_q == 17'd2) begin
      seq_d = {rx_byte_i, seq_q[7:0]};
    end else if (pos_q == 17'd3) begin
      len_d    = {8'h00, rx_byte_i};
      len_hi_d = 1'b0;
    end else if (pos_q == 17'd4) begin
      len_d = {rx_byte_i, len_q[7:0]};
    end else if (pos_q == 17'd5) begin
      len_hi_d = (rx_byte_i != 8'h00);
    end else if (pos_q == 17'd6) begin
      ok = !len_hi_q && (rx_byte_i == 8'h00) && (len_q != 16'd0) &&
           (len_q <= max_payload_i);
    end else if (pos_q == 17'd7) begin
      ok = (rx_byte_i == FRAME_TOKEN);
    end else if (pos_q == body_end) begin
      crc_lo_d = rx_byte_i;
    end else if (pos_q == body_end + 17'd1) begin
      ok   = ({rx_byte_i, crc_lo_q} == crc_q);
      done = ok;
    end

    crc_d = crc_base;
    if (ok) begin
      if (pos_q < body_end) begin
        crc_d = crc16_byte(crc_base, rx_byte_i);
      end
      pos_d           = done ? 17'd0 : pos_q + 17'd1;
      result_d.status = done ? STATUS_DONE : STATUS_BUSY;
    end else begin
      result_d.status = STATUS_ERROR;
      err_pos_d       = pos_q;
      pos_d           = 17'd0;
      len_d           = 16'd0;
      len_hi_d        = 1'b0;
    end

    result_d.seq_number     = seq_d;
    result_d.msg_length     = len_d;
    result_d.error_position = err_pos_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      len_q       <= '0;
      len_hi_q    <= 1'b0;
      seq_q       <= '0;
      crc_q       <= '0;
      crc_lo_q    <= '0;
      err_pos_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_o) begin
        pos_q     <= pos_d;
        len_q     <= len_d;
        len_hi_q  <= len_hi_d;
        seq_q     <= seq_d;
        crc_q     <= crc_d;
        crc_lo_q  <= crc_lo_d;
        err_pos_q <= err_pos_d;
      end
      if (take_o) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;
endmodule

// ----- sv/framed_message_receiver_crc16.sv -----
// Framed message receiver: takes one received byte per request and parses frames of the form
// start byte 0x1B, 16-bit sequence number, 32-bit length, token 0x0E, payload, and a CRC-16
// (reflected, polynomial 0x8408, initial value 0xFFFF), all little-endian. Every byte gives
// exactly one result: status (in progress, complete with good CRC, or format or CRC error), the
// payload byte with its offset when the byte is payload, and the current sequence number,
// length and last error position. The block sustains one byte per clock cycle while m_tready
// keeps results flowing; each byte passes through one input register and one result register,
// with the byte-wide CRC update and the frame position compare in between.
// Write max_payload at address 0 only while the block is idle.
`include "framed_message_receiver_crc16_defines.svh"

module framed_message_receiver_crc16 (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // [7:0] rx_byte
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // [7:0] body_byte, [23:8] body_offset, [39:24] seq_number, [55:40] msg_length,
  // [72:56] error_position, [79:73] zero
  output logic [79:0]                 m_tdata,
  output logic [2:0]                  m_tuser,   // [1:0] status, [2] body_valid
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fmr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import fmr_pkg::*;

  logic [15:0] max_payload;
  logic        take;
  logic        byte_valid;
  logic [7:0]  rx_byte;
  fmr_result_t result;

  fmr_cfg_regs u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .max_payload_o (max_payload)
  );

  fmr_in_reg u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tdata_i    (s_tdata),
    .take_i       (take),
    .s_tready_o   (s_tready),
    .byte_valid_o (byte_valid),
    .byte_o       (rx_byte)
  );

  fmr_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_valid_i  (byte_valid),
    .rx_byte_i     (rx_byte),
    .max_payload_i (max_payload),
    .m_tready_i    (m_tready),
    .take_o        (take),
    .out_valid_o   (m_tvalid),
    .result_o      (result)
  );

  assign m_tdata = {7'd0, result.error_position, result.msg_length, result.seq_number,
                    result.body_offset, result.body_byte};
  assign m_tuser = {result.body_valid, result.status};

  `FMR_ASSERT_IMP(a_err_not_body, clk_i, rst_ni,
                  m_tvalid && (m_tuser[1:0] == STATUS_ERROR), !m_tuser[2],
                  "Error status reported on a payload byte.")
  `FMR_ASSERT_IMP(a_done_has_len, clk_i, rst_ni,
                  m_tvalid && (m_tuser[1:0] == STATUS_DONE), m_tdata[55:40] != 16'd0,
                  "Completed frame reports a zero length.")
  `FMR_ASSERT_IMP(a_stall_blocks, clk_i, rst_ni,
                  byte_valid && m_tvalid && !m_tready, !s_tready && !take,
                  "Input taken while both stages are stalled.")
  `FMR_ASSERT_NEXT(a_take_gives_out, clk_i, rst_ni, take, m_tvalid,
                   "Taken byte produced no result.")
endmodule
